// ----- rtl/ple_pkg.sv -----
// ple_pkg: shared types and constants for the positional list engine.
// No dependencies; used by ple_cell and positional_list_engine_unit.

package ple_pkg;

	localparam int CAPACITY   = 16;
	localparam int DATA_WIDTH = 32;
	localparam int IDX_W      = $clog2(CAPACITY);
	localparam int COUNT_W    = $clog2(CAPACITY + 1);

	typedef logic [DATA_WIDTH-1:0] data_t;

	typedef enum logic [2:0] {
		KIND_INSERT  = 3'd0,
		KIND_DELETE  = 3'd1,
		KIND_REWRITE = 3'd2,
		KIND_READ    = 3'd3,
		KIND_SEARCH  = 3'd4,
		KIND_CLEAR   = 3'd5
	} kind_t;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_ILLEGAL   = 3'd1,
		ST_EMPTY     = 3'd2,
		ST_NOT_FOUND = 3'd3,
		ST_FULL      = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_LOAD,
		CELL_FROM_PREV,
		CELL_FROM_NEXT
	} cell_op_t;

	typedef struct packed {
		cell_op_t op;
		data_t    wdata;
	} cell_ctrl_t;

endpackage

// ----- rtl/positional_list_engine_unit.sv -----
// positional_list_engine_unit: bounded positional list built as a row of cells.
// Depends on ple_pkg and ple_cell.
//
// Requests arrive on the s_ channel (kind in s_tuser, position and value in
// s_tdata); results leave on the m_ channel through a single output register.
// Insert and delete shift the cells right of the position by one slot together;
// rewrite loads one cell; read selects one cell.
// Every kind but a matching search has its result registered straight into the
// output register on transfer; a matching search first registers its match vector.
// Throughput: one request per cycle while the receiver keeps up. A search that
// matches holds s_tready low while its match vector is walked, one result per
// cycle while the receiver keeps up, lowest position first.
// A stalled receiver holds the result in the output register; s_tready drops
// until it is taken, so nothing is lost or reordered.
// Reset clears the length, the output valid and the search walk; entry
// contents are not reset and are only read below the current length.

module positional_list_engine_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // [7:0] position, [39:8] value
	input  logic [2:0]  s_tuser,   // [2:0] kind
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,   // [31:0] read_value, [36:32] found_position,
	                               // [41:37] list_length, [42] list_empty
	output logic [2:0]  m_tuser,   // [2:0] status
	output logic        m_tlast
);

	localparam int CAP = ple_pkg::CAPACITY;

	logic                          fire;
	logic                          out_free;
	ple_pkg::kind_t                kind;
	logic [7:0]                    pos;
	ple_pkg::data_t                value_w;
	logic [7:0]                    cnt8;
	logic [ple_pkg::IDX_W-1:0]     pidx;

	logic [ple_pkg::COUNT_W-1:0]   count_q, count_nx;
	logic                          srch_q;
	logic [CAP-1:0]                mvec_q;
	ple_pkg::data_t                key_q;

	logic                          out_valid_q;
	ple_pkg::status_t              out_status_q;
	logic [31:0]                   out_value_q;
	logic [4:0]                    out_fpos_q;
	logic [4:0]                    out_len_q;
	logic                          out_empty_q;
	logic                          out_last_q;

	ple_pkg::cell_ctrl_t           cell_ctrl [CAP];
	ple_pkg::data_t                cell_data [CAP];
	logic [CAP-1:0]                cell_match;
	logic [CAP-1:0]                live;
	logic [CAP-1:0]                match_vec;

	ple_pkg::status_t              req_status;
	logic                          req_ok;
	logic [31:0]                   req_value;
	logic                          start_search;

	logic [CAP-1:0]                low_bit;
	logic [CAP-1:0]                mvec_rest;
	logic [ple_pkg::IDX_W-1:0]     low_idx;
	logic                          walk;

	assign kind     = ple_pkg::kind_t'(s_tuser);
	assign pos      = s_tdata[7:0];
	assign value_w  = ple_pkg::data_t'(signed'(s_tdata[39:8]));
	assign cnt8     = 8'(count_q);
	assign pidx     = ple_pkg::IDX_W'(pos - 8'd1);
	assign out_free = !out_valid_q || m_tready;
	assign s_tready = !srch_q && out_free;
	assign fire     = s_tvalid && s_tready;
	assign walk     = srch_q && out_free;

	genvar g;
	generate
		for (g = 0; g < CAP; g++) begin : g_cell
			ple_pkg::data_t prev_d, next_d;
			if (g == 0) begin : g_first
				assign prev_d = cell_data[g];
			end else begin : g_mid
				assign prev_d = cell_data[g-1];
			end
			if (g == CAP - 1) begin : g_tail
				assign next_d = cell_data[g];
			end else begin : g_body
				assign next_d = cell_data[g+1];
			end
			ple_cell u_cell (
				.clk       (clk),
				.ctrl      (cell_ctrl[g]),
				.prev_data (prev_d),
				.next_data (next_d),
				.key       (value_w),
				.data      (cell_data[g]),
				.match     (cell_match[g])
			);
			assign live[g] = (g < int'(count_q));
		end
	endgenerate

	assign match_vec = cell_match & live;

	always_comb begin
		req_status   = ple_pkg::ST_OK;
		req_ok       = 1'b0;
		req_value    = '0;
		start_search = 1'b0;
		count_nx     = count_q;
		case (kind)
			ple_pkg::KIND_INSERT: begin
				if (cnt8 == 8'(CAP)) begin
					req_status = ple_pkg::ST_FULL;
				end else if (pos == 8'd0 || pos > cnt8 + 8'd1) begin
					req_status = ple_pkg::ST_ILLEGAL;
				end else begin
					req_ok   = 1'b1;
					count_nx = count_q + 1'b1;
				end
			end
			ple_pkg::KIND_DELETE, ple_pkg::KIND_REWRITE, ple_pkg::KIND_READ: begin
				if (count_q == '0) begin
					req_status = ple_pkg::ST_EMPTY;
				end else if (pos == 8'd0 || pos > cnt8) begin
					req_status = ple_pkg::ST_ILLEGAL;
				end else begin
					req_ok = 1'b1;
					if (kind == ple_pkg::KIND_DELETE)
						count_nx = count_q - 1'b1;
					if (kind == ple_pkg::KIND_READ)
						req_value = cell_data[pidx][31:0];
				end
			end
			ple_pkg::KIND_SEARCH: begin
				if (count_q == '0)
					req_status = ple_pkg::ST_EMPTY;
				else if (match_vec == '0)
					req_status = ple_pkg::ST_NOT_FOUND;
				else
					start_search = 1'b1;
			end
			ple_pkg::KIND_CLEAR: begin
				count_nx = '0;
			end
			default: begin
				req_status = ple_pkg::ST_OK;
			end
		endcase
	end

	always_comb begin
		for (int i = 0; i < CAP; i++) begin
			cell_ctrl[i].op    = ple_pkg::CELL_HOLD;
			cell_ctrl[i].wdata = value_w;
			if (fire && req_ok) begin
				case (kind)
					ple_pkg::KIND_INSERT: begin
						if (8'(i + 1) == pos)
							cell_ctrl[i].op = ple_pkg::CELL_LOAD;
						else if (8'(i + 1) > pos)
							cell_ctrl[i].op = ple_pkg::CELL_FROM_PREV;
					end
					ple_pkg::KIND_DELETE: begin
						if (8'(i + 1) >= pos)
							cell_ctrl[i].op = ple_pkg::CELL_FROM_NEXT;
					end
					ple_pkg::KIND_REWRITE: begin
						if (8'(i + 1) == pos)
							cell_ctrl[i].op = ple_pkg::CELL_LOAD;
					end
					default: cell_ctrl[i].op = ple_pkg::CELL_HOLD;
				endcase
			end
		end
	end

	// lowest pending match
	assign low_bit   = mvec_q & (~mvec_q + 1'b1);
	assign mvec_rest = mvec_q & ~low_bit;

	always_comb begin
		low_idx = '0;
		for (int i = 0; i < CAP; i++) begin
			if (low_bit[i])
				low_idx = low_idx | ple_pkg::IDX_W'(i);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			srch_q  <= 1'b0;
		end else begin
			if (fire)
				count_q <= count_nx;
			if (fire && start_search)
				srch_q <= 1'b1;
			else if (walk && mvec_rest == '0)
				srch_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && start_search) begin
			mvec_q <= match_vec;
			key_q  <= value_w;
		end else if (walk) begin
			mvec_q <= mvec_rest;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire) begin
			out_valid_q <= !start_search;
		end else if (walk) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			out_status_q <= req_status;
			out_value_q  <= req_value;
			out_fpos_q   <= '0;
			out_len_q    <= 5'(count_nx);
			out_empty_q  <= (count_nx == '0);
			out_last_q   <= 1'b1;
		end else if (walk) begin
			out_status_q <= ple_pkg::ST_OK;
			out_value_q  <= key_q[31:0];
			out_fpos_q   <= 5'(low_idx) + 5'd1;
			out_len_q    <= 5'(count_q);
			out_empty_q  <= (count_q == '0);
			out_last_q   <= (mvec_rest == '0);
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_status_q;
	assign m_tlast  = out_last_q;
	assign m_tdata  = {5'd0, out_empty_q, out_len_q, out_fpos_q, out_value_q};

`ifndef SYNTH
	a_no_accept_in_walk: assert property (@(posedge clk) disable iff (!arst_n)
		srch_q |-> !s_tready)
		else $error("request taken during search walk");

	a_walk_has_match: assert property (@(posedge clk) disable iff (!arst_n)
		srch_q |-> mvec_q != '0)
		else $error("search walk with no pending match");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		int'(count_q) <= CAP)
		else $error("length above capacity");

	a_not_last_is_match: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tlast |-> m_tuser == ple_pkg::ST_OK && out_fpos_q != 5'd0)
		else $error("non-final result that is not a match");
`endif

endmodule

// ----- rtl/ple_cell.sv -----
// ple_cell: one list slot; loads, holds or takes its neighbour's entry.
// Depends on ple_pkg. Instanced CAPACITY times by the top level.

module ple_cell (
	input  logic                clk,
	input  ple_pkg::cell_ctrl_t ctrl,
	input  ple_pkg::data_t      prev_data,
	input  ple_pkg::data_t      next_data,
	input  ple_pkg::data_t      key,
	output ple_pkg::data_t      data,
	output logic                match
);

	ple_pkg::data_t data_q;

	always_ff @(posedge clk) begin
		case (ctrl.op)
			ple_pkg::CELL_LOAD:      data_q <= ctrl.wdata;
			ple_pkg::CELL_FROM_PREV: data_q <= prev_data;
			ple_pkg::CELL_FROM_NEXT: data_q <= next_data;
			default:                 data_q <= data_q;
		endcase
	end

	assign data  = data_q;
	assign match = (data_q == key);

endmodule

// ----- test/list_result_checker.sv -----
// list_result_checker: watches both stream channels of the positional list engine, keeps a
// shadow list that predicts every response, and compares each response field by field.
// Depends on ple_pkg.

module list_result_checker
	import ple_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [39:0] s_tdata,   // [7:0] position, [39:8] value
	input  logic [2:0]  s_tuser,   // [2:0] kind
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [47:0] m_tdata,   // [31:0] read_value, [36:32] found_position,
	                               // [41:37] list_length, [42] list_empty
	input  logic [2:0]  m_tuser,   // [2:0] status
	input  logic        m_tlast,
	output int          fail_count,
	output int          pending_results
);

	typedef struct {
		status_t    status;
		data_t      read_value;
		logic [4:0] found_position;
		logic [4:0] list_length;
		logic       list_empty;
		logic       last;
	} list_response_t;

	list_response_t awaited_responses[$];
	data_t          shadow_entries [CAPACITY];
	int             shadow_len;

	function automatic list_response_t make_response(status_t st, data_t rv, int fp, logic lst);
		list_response_t r;
		r.status         = st;
		r.read_value     = rv;
		r.found_position = 5'(fp);
		r.list_length    = 5'(shadow_len);
		r.list_empty     = (shadow_len == 0);
		r.last           = lst;
		return r;
	endfunction

	task automatic apply_list_request(logic [2:0] k, int p, data_t v);
		int             i;
		int             hits;
		list_response_t tail_hit;
		hits = 0;
		case (k)
			KIND_INSERT: begin
				if (shadow_len >= CAPACITY) begin
					awaited_responses.push_back(make_response(ST_FULL, '0, 0, 1'b1));
				end else if (p < 1 || p > shadow_len + 1) begin
					awaited_responses.push_back(make_response(ST_ILLEGAL, '0, 0, 1'b1));
				end else begin
					for (i = shadow_len; i >= p; i--)
						shadow_entries[i] = shadow_entries[i-1];
					shadow_entries[p-1] = v;
					shadow_len++;
					awaited_responses.push_back(make_response(ST_OK, '0, 0, 1'b1));
				end
			end
			KIND_DELETE, KIND_REWRITE, KIND_READ: begin
				if (shadow_len == 0) begin
					awaited_responses.push_back(make_response(ST_EMPTY, '0, 0, 1'b1));
				end else if (p < 1 || p > shadow_len) begin
					awaited_responses.push_back(make_response(ST_ILLEGAL, '0, 0, 1'b1));
				end else if (k == KIND_DELETE) begin
					for (i = p; i < shadow_len; i++)
						shadow_entries[i-1] = shadow_entries[i];
					shadow_len--;
					awaited_responses.push_back(make_response(ST_OK, '0, 0, 1'b1));
				end else if (k == KIND_REWRITE) begin
					shadow_entries[p-1] = v;
					awaited_responses.push_back(make_response(ST_OK, '0, 0, 1'b1));
				end else begin
					awaited_responses.push_back(
						make_response(ST_OK, shadow_entries[p-1], 0, 1'b1));
				end
			end
			KIND_SEARCH: begin
				if (shadow_len == 0) begin
					awaited_responses.push_back(make_response(ST_EMPTY, '0, 0, 1'b1));
				end else begin
					for (i = 0; i < shadow_len; i++) begin
						if (shadow_entries[i] == v) begin
							awaited_responses.push_back(make_response(ST_OK, v, i + 1, 1'b0));
							hits++;
						end
					end
					if (hits == 0) begin
						awaited_responses.push_back(make_response(ST_NOT_FOUND, '0, 0, 1'b1));
					end else begin
						tail_hit = awaited_responses.pop_back();
						tail_hit.last = 1'b1;
						awaited_responses.push_back(tail_hit);
					end
				end
			end
			KIND_CLEAR: begin
				shadow_len = 0;
				awaited_responses.push_back(make_response(ST_OK, '0, 0, 1'b1));
			end
			default: begin
				awaited_responses.push_back(make_response(ST_OK, '0, 0, 1'b1));
			end
		endcase
	endtask

	task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			$error("%s mismatch: expected %0h, got %0h", name, want, got);
			fail_count++;
		end
	endtask

	task automatic match_response();
		list_response_t want;
		if (awaited_responses.size() == 0) begin
			$error("response with nothing outstanding: status %0d, value %0h",
				m_tuser, m_tdata[31:0]);
			fail_count++;
		end else begin
			want = awaited_responses.pop_front();
			check_field("status", want.status, m_tuser);
			check_field("read_value", want.read_value, m_tdata[31:0]);
			check_field("found_position", want.found_position, m_tdata[36:32]);
			check_field("list_length", want.list_length, m_tdata[41:37]);
			check_field("list_empty", want.list_empty, m_tdata[42]);
			check_field("padding", '0, m_tdata[47:43]);
			check_field("last", want.last, m_tlast);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			awaited_responses.delete();
			shadow_len = 0;
			fail_count = 0;
			pending_results <= 0;
		end else begin
			if (s_tvalid && s_tready)
				apply_list_request(s_tuser, int'(s_tdata[7:0]), s_tdata[39:8]);
			if (m_tvalid && m_tready)
				match_response();
			pending_results <= awaited_responses.size();
		end
	end

endmodule

// ----- test/positional_list_engine_unit_tb.sv -----
// positional_list_engine_unit_tb: drives list requests into the engine and gives the verdict.
// Depends on ple_pkg, positional_list_engine_unit and list_result_checker.

module positional_list_engine_unit_tb;
	import ple_pkg::*;

	localparam logic [2:0] KIND_SPARE_LO = 3'd6;
	localparam logic [2:0] KIND_SPARE_HI = 3'd7;
	localparam int STALL_LIMIT = 1000;
	localparam int HOLD_CYCLES = 48;
	localparam int PHASES      = 8;
	localparam int PHASE_ITEMS = 46;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [39:0] s_tdata;
	logic [2:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [47:0] m_tdata;
	logic [2:0]  m_tuser;
	logic        m_tlast;

	int fail_count;
	int pending_results;
	int idle_cycles = 0;
	int len_guess;
	bit sender_gaps;
	bit receiver_gaps;
	bit hold_request;

	data_t palette [0:4] = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
		32'h0000_5A5A};

	positional_list_engine_unit dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.m_tlast(m_tlast)
	);

	list_result_checker response_check (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.m_tlast(m_tlast), .fail_count(fail_count), .pending_results(pending_results)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= STALL_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// result side: random stall bursts, plus one long hold on request
	initial begin
		m_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_request) begin
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_request = 1'b0;
				m_tready <= 1'b1;
			end else if (receiver_gaps && $urandom_range(0, 4) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 6)) @(posedge clk);
				m_tready <= 1'b1;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	task automatic issue_request(input logic [2:0] k, input logic [7:0] p, input data_t v);
		if (sender_gaps && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= k;
		s_tdata  <= {v, p};
		do @(posedge clk); while (!s_tready);
		// rough length, only used to steer positions
		case (k)
			KIND_INSERT: if (len_guess < CAPACITY && p >= 1 && int'(p) <= len_guess + 1)
				len_guess++;
			KIND_DELETE: if (len_guess > 0 && p >= 1 && int'(p) <= len_guess)
				len_guess--;
			KIND_CLEAR: len_guess = 0;
			default: ;
		endcase
	endtask

	task automatic drain_responses();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (pending_results != 0);
	endtask

	function automatic logic [7:0] pick_position(logic [2:0] k);
		int room;
		int r;
		room = (k == KIND_INSERT) ? len_guess + 1 : len_guess;
		r = $urandom_range(0, 19);
		if (r == 0)
			return 8'd0;
		if (r == 1)
			return 8'(room + 1);
		if (r == 2)
			return 8'($urandom_range(0, 255));
		if (room == 0)
			return 8'($urandom_range(0, 3));
		if (r == 3)
			return 8'd1;
		if (r == 4)
			return 8'(room);
		return 8'($urandom_range(1, room));
	endfunction

	function automatic data_t pick_value();
		if ($urandom_range(0, 9) < 6)
			return palette[$urandom_range(0, 4)];
		return $urandom();
	endfunction

	function automatic logic [2:0] pick_kind(int insert_weight);
		int r;
		r = $urandom_range(0, 99);
		if (r < insert_weight)
			return KIND_INSERT;
		if (r < insert_weight + 15)
			return KIND_DELETE;
		if (r < insert_weight + 25)
			return KIND_REWRITE;
		if (r < insert_weight + 41)
			return KIND_SEARCH;
		if (r < insert_weight + 43)
			return KIND_CLEAR;
		if (r < insert_weight + 45)
			return 3'($urandom_range(KIND_SPARE_LO, KIND_SPARE_HI));
		return KIND_READ;
	endfunction

	initial begin
		logic [2:0] k;
		data_t      fill_value;
		s_tvalid <= 1'b0;
		s_tdata  <= '0;
		s_tuser  <= KIND_INSERT;
		arst_n   <= 1'b0;
		len_guess     = 0;
		sender_gaps   = 1'b1;
		receiver_gaps = 1'b1;
		hold_request  = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty list, bad insert positions, head/tail/middle inserts
		issue_request(KIND_READ, 8'd1, '0);
		issue_request(KIND_DELETE, 8'd1, '0);
		issue_request(KIND_REWRITE, 8'd1, 32'h1234_5678);
		issue_request(KIND_SEARCH, 8'd0, '0);
		issue_request(KIND_INSERT, 8'd0, 32'h1);
		issue_request(KIND_INSERT, 8'd2, 32'h1);
		issue_request(KIND_INSERT, 8'd1, 32'h8000_0000);
		issue_request(KIND_INSERT, 8'd2, 32'h7FFF_FFFF);
		issue_request(KIND_INSERT, 8'd1, 32'hFFFF_FFFF);
		issue_request(KIND_INSERT, 8'd2, 32'h8000_0000);
		issue_request(KIND_READ, 8'd0, '0);
		issue_request(KIND_READ, 8'd5, '0);
		issue_request(KIND_READ, 8'd255, '0);
		issue_request(KIND_READ, 8'd4, '0);
		issue_request(KIND_SEARCH, 8'd0, 32'h8000_0000);
		issue_request(KIND_SEARCH, 8'd0, 32'h0);
		issue_request(KIND_REWRITE, 8'd1, 32'h0);
		issue_request(KIND_DELETE, 8'd4, '0);
		issue_request(KIND_DELETE, 8'd1, '0);
		issue_request(KIND_SPARE_LO, 8'd1, 32'hFFFF_FFFF);
		issue_request(KIND_SPARE_HI, 8'hFF, 32'hFFFF_FFFF);
		issue_request(KIND_CLEAR, 8'd0, '0);
		// sole entry removed leaves an empty list
		issue_request(KIND_INSERT, 8'd1, 32'hA5A5_A5A5);
		issue_request(KIND_DELETE, 8'd1, '0);
		issue_request(KIND_READ, 8'd1, '0);
		drain_responses();

		// full list of one value: full status and a search matching every entry
		fill_value = pick_value();
		issue_request(KIND_CLEAR, 8'd0, '0);
		repeat (CAPACITY) issue_request(KIND_INSERT, 8'(len_guess + 1), fill_value);
		issue_request(KIND_INSERT, 8'd1, ~fill_value);
		issue_request(KIND_SEARCH, 8'd0, fill_value);
		issue_request(KIND_READ, 8'(CAPACITY), '0);
		issue_request(KIND_DELETE, 8'(CAPACITY), '0);
		drain_responses();

		for (int ph = 0; ph < PHASES; ph++) begin
			if (ph == PHASES - 1) begin
				sender_gaps   = 1'b0;
				receiver_gaps = 1'b0;
			end
			if (ph == 2)
				hold_request = 1'b1;
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				k = pick_kind(ph[0] ? 25 : 40);
				issue_request(k, pick_position(k), pick_value());
			end
			drain_responses();
		end

		repeat (8) @(posedge clk);
		if (fail_count == 0 && pending_results == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule

// ----- filelist.f -----
rtl/ple_pkg.sv
rtl/ple_cell.sv
rtl/positional_list_engine_unit.sv
test/list_result_checker.sv
test/positional_list_engine_unit_tb.sv
